FILE: rtl/core/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types and constants of the melody note sequencer.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int CFG_DATA_W     = 9;
    localparam int SONG_LEN_MAX   = 256;
    localparam int HALF_PERIOD_NUM = 500000;
    localparam int LEVEL_BASE     = 200;
    localparam int LEVEL_STEP     = 80;
    localparam int LEVEL_MAX      = 8;
    localparam int FRAME_COUNT    = 6;
    localparam int DIV_STEPS      = 19;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_SONG_START  = 1'b0,
        CFG_SONG_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_NOTE   = 2'd1,
        ACC_PLAY   = 2'd2,
        ACC_REDUCE = 2'd3
    } t_acc_sel;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [7:0]  note_addr;
        logic [15:0] note_freq;
        logic [15:0] note_duration;
        logic [7:0]  note_vibe;
    } t_in_item;

    typedef struct packed {
        logic [18:0] half_period_us;
        logic [3:0]  note_level;
        logic        motor_on;
        logic        note_advanced;
        logic [2:0]  dance_frame;
    } t_out_item;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
        logic [7:0]  vibe;
    } t_note;

    typedef struct packed {
        logic     in_ready;
        logic     take;
        t_acc_sel acc_sel;
        logic     ram_we;
        logic     ram_re;
        logic     advance;
        logic     load_note;
        logic     div_step;
        logic     tick;
        logic     out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        t_cmd in_cmd;
        logic acc_ok;
        logic elapsed_ok;
        logic note_rest;
        logic div_last;
        logic out_free;
    } t_ctrl_status;

    // level 0 for a rest, level 1 below the first threshold (360 Hz), then one step per 80 Hz, capped at 8
    function automatic logic [3:0] pitch_level_of(input logic [15:0] freq);
        logic [3:0] lv;
        lv = (freq == 16'd0) ? 4'd0 : 4'd1;
        for (int k = 2; k <= LEVEL_MAX; k++) begin
            if (32'(freq) >= LEVEL_BASE + LEVEL_STEP * k) begin
                lv = 4'(k);
            end
        end
        return lv;
    endfunction

endpackage

FILE: rtl/core/msq_stream_if.sv
// ----------------------------------------------------------------------------
// msq_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface msq_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/msq_ram.sv
// ----------------------------------------------------------------------------
// msq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/msq_ctrl.sv
// ----------------------------------------------------------------------------
// msq_ctrl
// Sequencing state machine: address reduction, note check, note load,
// divider iterations and result hand-off.
// ----------------------------------------------------------------------------
module msq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msq_pkg::t_ctrl_status i_status,
    output msq_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WADDR = 8'b0000_0010,
        S_PADDR = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_NADDR = 8'b0001_0000,
        S_NLOAD = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    msq_pkg::t_ctrl_cmd w_cmd;

    always_comb begin
        w_cmd         = '0;
        w_cmd.acc_sel = msq_pkg::ACC_HOLD;
        n_state       = r_state;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    w_cmd.take = 1'b1;
                    unique case (i_status.in_cmd)
                        msq_pkg::CMD_STEP: begin
                            w_cmd.acc_sel = msq_pkg::ACC_PLAY;
                            n_state       = S_PADDR;
                        end
                        msq_pkg::CMD_WRITE: begin
                            w_cmd.acc_sel = msq_pkg::ACC_NOTE;
                            n_state       = S_WADDR;
                        end
                        msq_pkg::CMD_TICK: begin
                            w_cmd.tick = 1'b1;
                            n_state    = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WADDR: begin
                if (i_status.acc_ok) begin
                    w_cmd.ram_we = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    w_cmd.acc_sel = msq_pkg::ACC_REDUCE;
                end
            end
            S_PADDR: begin
                if (i_status.acc_ok) begin
                    w_cmd.ram_re = 1'b1;
                    n_state      = S_CHK;
                end else begin
                    w_cmd.acc_sel = msq_pkg::ACC_REDUCE;
                end
            end
            S_CHK: begin
                if (i_status.elapsed_ok) begin
                    w_cmd.advance = 1'b1;
                    w_cmd.acc_sel = msq_pkg::ACC_PLAY;
                    n_state       = S_NADDR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NADDR: begin
                if (i_status.acc_ok) begin
                    w_cmd.ram_re = 1'b1;
                    n_state      = S_NLOAD;
                end else begin
                    w_cmd.acc_sel = msq_pkg::ACC_REDUCE;
                end
            end
            S_NLOAD: begin
                w_cmd.load_note = 1'b1;
                n_state         = i_status.note_rest ? S_DONE : S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

endmodule

FILE: rtl/core/msq_datapath.sv
// ----------------------------------------------------------------------------
// msq_datapath
// Note memory, song position and timing, serial tone divider, motor timer,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module msq_datapath #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  msq_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [msq_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  msq_pkg::t_ctrl_cmd                i_cmd,
    output msq_pkg::t_ctrl_status             o_status,
    msq_stream_if.sink                        i_in,
    msq_stream_if.source                      o_out
);

    localparam int AW    = $clog2(NOTE_DEPTH);
    localparam int ACC_W = (AW + 1 > 9) ? AW + 1 : 9;
    localparam logic [ACC_W-1:0] DEPTH_C = ACC_W'(NOTE_DEPTH);

    // configuration
    logic [7:0]  r_song_start;
    logic [8:0]  r_song_len;

    // captured beat
    logic [31:0] r_now;
    logic [15:0] r_wfreq;
    logic [15:0] r_wdur;
    logic [7:0]  r_wvibe;

    // player state
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [7:0]  r_pos;
    logic [31:0] r_start_ms;
    logic [18:0] r_tone;
    logic [3:0]  r_level;
    logic [7:0]  r_mcount;
    logic        r_motor;
    logic [2:0]  r_frame;
    logic        r_adv;

    // tone divider
    logic [15:0] r_div_den;
    logic [15:0] r_div_rem;
    logic [18:0] r_div_quo;
    logic [msq_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic                r_out_valid;
    msq_pkg::t_out_item  r_out;

    msq_pkg::t_note w_rdata;
    logic [39:0]    w_rdata_raw;
    logic [8:0]  w_eff_len;
    logic [8:0]  w_pos_inc;
    logic [7:0]  w_next_pos;
    logic [7:0]  w_play_pos;
    logic [8:0]  w_play_sum;
    logic        w_acc_ok;
    logic [31:0] w_elapsed;
    logic [16:0] w_div_trial;
    logic [16:0] w_div_diff;
    logic        w_div_ge;
    logic        w_out_free;

    msq_ram #(
        .WIDTH(40),
        .DEPTH(NOTE_DEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (r_acc[AW-1:0]),
        .i_wdata ({r_wfreq, r_wdur, r_wvibe}),
        .i_re    (i_cmd.ram_re),
        .i_raddr (r_acc[AW-1:0]),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = msq_pkg::t_note'(w_rdata_raw);

    // length 0 behaves as 1, anything above the song limit as the limit
    always_comb begin
        if (r_song_len == 9'd0) begin
            w_eff_len = 9'd1;
        end else if (r_song_len > 9'(msq_pkg::SONG_LEN_MAX)) begin
            w_eff_len = 9'(msq_pkg::SONG_LEN_MAX);
        end else begin
            w_eff_len = r_song_len;
        end
    end

    assign w_pos_inc  = {1'b0, r_pos} + 9'd1;
    assign w_next_pos = (w_pos_inc >= w_eff_len) ? 8'd0 : w_pos_inc[7:0];
    assign w_play_pos = i_cmd.advance ? w_next_pos : r_pos;
    assign w_play_sum = {1'b0, r_song_start} + {1'b0, w_play_pos};
    assign w_acc_ok   = r_acc < DEPTH_C;
    assign w_elapsed  = r_now - r_start_ms;

    // address modulo depth by repeated subtraction
    always_comb begin
        n_acc = r_acc;
        unique case (i_cmd.acc_sel)
            msq_pkg::ACC_NOTE:   n_acc = ACC_W'(i_in.payload.note_addr);
            msq_pkg::ACC_PLAY:   n_acc = ACC_W'(w_play_sum);
            msq_pkg::ACC_REDUCE: n_acc = r_acc - DEPTH_C;
            default:             n_acc = r_acc;
        endcase
    end

    // one restoring division step per cycle
    assign w_div_trial = {r_div_rem, r_div_quo[18]};
    assign w_div_diff  = w_div_trial - {1'b0, r_div_den};
    assign w_div_ge    = w_div_trial >= {1'b0, r_div_den};

    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song_start <= 8'd0;
            r_song_len   <= 9'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                msq_pkg::CFG_SONG_START:  r_song_start <= i_cfg_data[7:0];
                msq_pkg::CFG_SONG_LENGTH: r_song_len   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_now   <= i_in.payload.now_ms;
            r_wfreq <= i_in.payload.note_freq;
            r_wdur  <= i_in.payload.note_duration;
            r_wvibe <= i_in.payload.note_vibe;
        end
        r_acc <= n_acc;
        if (i_cmd.load_note) begin
            r_div_den <= w_rdata.freq;
            r_div_rem <= 16'd0;
            r_div_quo <= 19'(msq_pkg::HALF_PERIOD_NUM);
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_div_ge ? w_div_diff[15:0] : w_div_trial[15:0];
            r_div_quo <= {r_div_quo[17:0], w_div_ge};
        end
        if (i_cmd.out_load) begin
            r_out.half_period_us <= r_tone;
            r_out.note_level     <= r_level;
            r_out.motor_on       <= r_motor;
            r_out.note_advanced  <= r_adv;
            r_out.dance_frame    <= r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 8'd0;
            r_start_ms  <= 32'd0;
            r_tone      <= 19'd0;
            r_level     <= 4'd0;
            r_mcount    <= 8'd0;
            r_motor     <= 1'b0;
            r_frame     <= 3'd0;
            r_adv       <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_adv <= 1'b0;
            end
            if (i_cmd.advance) begin
                r_start_ms <= r_now;
                r_pos      <= w_next_pos;
                r_adv      <= 1'b1;
            end
            if (i_cmd.load_note) begin
                r_level   <= msq_pkg::pitch_level_of(w_rdata.freq);
                r_div_cnt <= '0;
                if (w_rdata.freq == 16'd0) begin
                    r_tone <= 19'd0;
                end
                if (w_rdata.vibe != 8'd0) begin
                    r_mcount <= w_rdata.vibe;
                    r_motor  <= 1'b1;
                end
                r_frame <= (r_frame == 3'(msq_pkg::FRAME_COUNT - 1)) ? 3'd0 : r_frame + 3'd1;
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + msq_pkg::DIV_CNT_W'(1);
                if (r_div_cnt == msq_pkg::DIV_CNT_W'(msq_pkg::DIV_STEPS - 1)) begin
                    r_tone <= {r_div_quo[17:0], w_div_ge};
                end
            end
            if (i_cmd.tick && (r_mcount != 8'd0)) begin
                r_mcount <= r_mcount - 8'd1;
                if (r_mcount == 8'd1) begin
                    r_motor <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready    = i_cmd.in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign o_status.in_valid   = i_in.valid;
    assign o_status.in_cmd     = msq_pkg::t_cmd'(i_in.payload.cmd);
    assign o_status.acc_ok     = w_acc_ok;
    assign o_status.elapsed_ok = w_elapsed >= 32'(w_rdata.dur);
    assign o_status.note_rest  = w_rdata.freq == 16'd0;
    assign o_status.div_last   = r_div_cnt == msq_pkg::DIV_CNT_W'(msq_pkg::DIV_STEPS - 1);
    assign o_status.out_free   = w_out_free;

endmodule

FILE: rtl/core/melody_note_sequencer.sv
// ----------------------------------------------------------------------------
// melody_note_sequencer
// Note memory player: tone half period, pitch level, motor drive and frame.
// ----------------------------------------------------------------------------
// Input beats arrive on i_in (cmd, now_ms and note fields); every beat gives
// exactly one result beat on o_out with the tone half period, pitch level,
// motor drive, advance flag and dance frame after that command.
// song_start and song_length are written through i_cfg_we/i_cfg_idx/
// i_cfg_data; the user must write them only while the block is idle, as the block itself does not enforce it.
// One beat is worked on at a time. A player step that does not advance
// reduces the address, reads the note and checks its duration; one that starts
// a new tone adds the note fetch and the 19-step serial divider for
// 500000/freq. Each note memory address is reduced modulo the depth by
// subtraction, one extra subtraction per multiple of NOTE_DEPTH in start plus
// position (none or one at depth 256). The result waits in an output
// register, so the next beat is accepted while the receiver stalls; the block
// only holds at its end if that register is still full. Reset clears
// position, timing, tone, level, motor and frame and restores the song
// registers; note memory holds whatever it holds until written.
// ----------------------------------------------------------------------------
module melody_note_sequencer #(
    parameter int NOTE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  msq_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [msq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    msq_stream_if.sink                     i_in,
    msq_stream_if.source                   o_out
);

    msq_pkg::t_ctrl_cmd    w_cmd;
    msq_pkg::t_ctrl_status w_status;

    msq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    msq_datapath #(
        .NOTE_DEPTH(NOTE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule
